// ----- sv/isf_pkg.sv -----
// image format sniffer package: format codes and magic-number constants
// no dependencies; imported by image_format_sniffer

package isf_pkg;

  // format codes, in priority order of the checks
  typedef enum logic [4:0] {
    FMT_UNKNOWN = 5'd0,
    FMT_WEBM    = 5'd1,
    FMT_TIFF    = 5'd2,
    FMT_DDS     = 5'd3,
    FMT_PSD     = 5'd4,
    FMT_JXR     = 5'd5,
    FMT_EXR     = 5'd6,
    FMT_PIC     = 5'd7,
    FMT_ICO     = 5'd8,
    FMT_CUR     = 5'd9,
    FMT_BMP     = 5'd10,
    FMT_JPG     = 5'd11,
    FMT_PNG     = 5'd12,
    FMT_XCF     = 5'd13,
    FMT_GIF     = 5'd14,
    FMT_WEBP    = 5'd15,
    FMT_AVIF    = 5'd16,
    FMT_HEIC    = 5'd17,
    FMT_HEIF    = 5'd18,
    FMT_TGA     = 5'd19,
    FMT_PCX     = 5'd20,
    FMT_HDR     = 5'd21,
    FMT_PGM     = 5'd22,
    FMT_PPM     = 5'd23
  } format_e;

  // header widths
  localparam int unsigned HeaderWidth = 64;
  localparam int unsigned LengthWidth = 5;

  // length thresholds
  localparam logic [LengthWidth-1:0] MinLength = 5'd16;
  localparam logic [LengthWidth-1:0] TgaLength = 5'd18;

  // four-byte magic words, first byte in bits 7:0
  localparam logic [31:0] MagicWebm    = 32'hA3DF_451A;
  localparam logic [31:0] MagicTiffLe  = 32'h002A_4949;
  localparam logic [31:0] MagicTiffBe  = 32'h2A00_4D4D;
  localparam logic [31:0] MagicDds     = 32'h2053_4444;
  localparam logic [31:0] MagicPsd     = 32'h5350_4238;
  localparam logic [31:0] MagicJxr     = 32'h4342_4949;
  localparam logic [31:0] MagicExr     = 32'h0131_2F76;
  localparam logic [31:0] MagicPic     = 32'h2042_4950;
  localparam logic [31:0] MagicIco     = 32'h0001_0000;
  localparam logic [31:0] MagicCur     = 32'h0002_0000;
  localparam logic [15:0] MagicBmp     = 16'h4D42;
  localparam logic [23:0] MagicJpg     = 24'hFF_D8FF;
  localparam logic [31:0] MagicPngLo   = 32'h474E_5089;
  localparam logic [31:0] MagicPngHi   = 32'h0A1A_0A0D;
  localparam logic [31:0] MagicXcfLo   = 32'h706D_6967;
  localparam logic [31:0] MagicXcfHi   = 32'h6663_7820;
  localparam logic [31:0] MagicGif     = 32'h3846_4947;
  localparam logic [15:0] MagicGif87   = 16'h6137;
  localparam logic [15:0] MagicGif89   = 16'h6139;
  localparam logic [31:0] MagicRiff    = 32'h4646_4952;
  localparam logic [31:0] MagicWebp    = 32'h5042_4557;
  localparam logic [31:0] MagicFtyp    = 32'h7079_7466;
  localparam logic [31:0] BrandAvif    = 32'h6669_7661;
  localparam logic [31:0] BrandAvis    = 32'h7369_7661;
  localparam logic [31:0] BrandHeic    = 32'h6369_6568;
  localparam logic [31:0] BrandHeix    = 32'h7869_6568;
  localparam logic [31:0] BrandHevc    = 32'h6376_6568;
  localparam logic [31:0] BrandHevx    = 32'h7876_6568;

  // radiance headers
  localparam logic [63:0] MagicRadLo   = 64'h4E41_4944_4152_3F23;
  localparam logic [15:0] MagicRadHi   = 16'h4543;
  localparam logic [47:0] MagicRgbe    = 48'h4542_4752_3F23;

  // single bytes
  localparam logic [7:0] BytePcx      = 8'h0A;
  localparam logic [7:0] PcxMaxVer    = 8'h05;
  localparam logic [7:0] ByteP        = 8'h50;
  localparam logic [7:0] ByteP2       = 8'h32;
  localparam logic [7:0] ByteP3       = 8'h33;
  localparam logic [7:0] ByteP5       = 8'h35;
  localparam logic [7:0] ByteP6       = 8'h36;
  localparam logic [7:0] TgaMaxCmap   = 8'h01;

endpackage

// ----- sv/image_format_sniffer.sv -----
// image format sniffer top level: magic-number classifier of a file header
// depends on isf_pkg for format codes and magic constants
//
// usage:
//   an item is the first 16 bytes of a file (header_low_i holds bytes 0..7,
//   header_high_i bytes 8..15, byte 0 in bits 7:0) plus file_length_i,
//   saturated at 18 by the sender. the item is taken at a clock edge where
//   start is high and busy is low; busy is always low, so one item can be
//   taken in every cycle.
//   each item gives one result: format_code_o is shown for one cycle with
//   valid_o high, starting at the edge after the one that took the item.
//   the path holds two registers (input register, then result register), throughput one
//   item per cycle; the classify logic between the two registers is a set of
//   parallel constant compares and a priority select.
//   reset clears both valid flags, so nothing is shown until a new item comes.
//   the receiver cannot stall: results are shown once and not held.
//   a file shorter than 16 bytes, or one that matches nothing, gives unknown.

module image_format_sniffer import isf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [HeaderWidth-1:0] header_low_i,
  input  logic [HeaderWidth-1:0] header_high_i,
  input  logic [LengthWidth-1:0] file_length_i,
  output logic                   valid_o,
  output logic [4:0]             format_code_o
);

  logic                   in_valid_q;
  logic [HeaderWidth-1:0] lo_q;
  logic [HeaderWidth-1:0] hi_q;
  logic [LengthWidth-1:0] len_q;
  logic                   out_valid_q;
  format_e                code_d;
  format_e                code_q;

  logic [31:0] w0, w1, w2;
  logic [7:0]  b0, b1, b2;
  logic        tga_type_ok;

  // never back-pressured
  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      lo_q  <= header_low_i;
      hi_q  <= header_high_i;
      len_q <= file_length_i;
    end
  end

  // header words and bytes
  assign w0 = lo_q[31:0];
  assign w1 = lo_q[63:32];
  assign w2 = hi_q[31:0];
  assign b0 = lo_q[7:0];
  assign b1 = lo_q[15:8];
  assign b2 = lo_q[23:16];

  // tga image type set
  always_comb begin
    tga_type_ok = b2 inside {8'd1, 8'd2, 8'd3, 8'd9, 8'd10, 8'd11};
  end

  // priority-ordered magic matching
  always_comb begin
    code_d = FMT_UNKNOWN;
    if (len_q < MinLength) begin
      code_d = FMT_UNKNOWN;
    end else if (w0 == MagicWebm) begin
      code_d = FMT_WEBM;
    end else if (w0 == MagicTiffLe || w0 == MagicTiffBe) begin
      code_d = FMT_TIFF;
    end else if (w0 == MagicDds) begin
      code_d = FMT_DDS;
    end else if (w0 == MagicPsd) begin
      code_d = FMT_PSD;
    end else if (w0 == MagicJxr) begin
      code_d = FMT_JXR;
    end else if (w0 == MagicExr) begin
      code_d = FMT_EXR;
    end else if (w0 == MagicPic) begin
      code_d = FMT_PIC;
    end else if (w0 == MagicIco) begin
      code_d = FMT_ICO;
    end else if (w0 == MagicCur) begin
      code_d = FMT_CUR;
    end else if (w0[15:0] == MagicBmp) begin
      code_d = FMT_BMP;
    end else if (w0[23:0] == MagicJpg) begin
      code_d = FMT_JPG;
    end else if (w0 == MagicPngLo && w1 == MagicPngHi) begin
      code_d = FMT_PNG;
    end else if (w0 == MagicXcfLo && w1 == MagicXcfHi) begin
      code_d = FMT_XCF;
    end else if (w0 == MagicGif && (w1[15:0] == MagicGif87 || w1[15:0] == MagicGif89)) begin
      code_d = FMT_GIF;
    end else if (w0 == MagicRiff && w2 == MagicWebp) begin
      code_d = FMT_WEBP;
    end else if (w1 == MagicFtyp && (w2 == BrandAvif || w2 == BrandAvis)) begin
      code_d = FMT_AVIF;
    end else if (w1 == MagicFtyp && (w2 == BrandHeic || w2 == BrandHeix)) begin
      code_d = FMT_HEIC;
    end else if (w1 == MagicFtyp && (w2 == BrandHevc || w2 == BrandHevx)) begin
      code_d = FMT_HEIF;
    end else if (len_q >= TgaLength && tga_type_ok && b1 <= TgaMaxCmap) begin
      code_d = FMT_TGA;
    end else if (b0 == BytePcx && b1 <= PcxMaxVer) begin
      code_d = FMT_PCX;
    end else if ((lo_q == MagicRadLo && hi_q[15:0] == MagicRadHi) ||
                 lo_q[47:0] == MagicRgbe) begin
      code_d = FMT_HDR;
    end else if (b0 == ByteP && (b1 == ByteP2 || b1 == ByteP5)) begin
      code_d = FMT_PGM;
    end else if (b0 == ByteP && (b1 == ByteP3 || b1 == ByteP6)) begin
      code_d = FMT_PPM;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      code_q <= code_d;
    end
  end

  assign valid_o       = out_valid_q;
  assign format_code_o = code_q;

endmodule
